### design/linear_diophantine_solver_defines.svh
// Assertion macros shared by the solver's RTL.
`ifndef LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH

// Implication checked in the same cycle, disabled while reset is high.
`define LDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle, disabled while reset is high.
`define LDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ldsolve_pkg.sv
`default_nettype none

package ldsolve_pkg;

  // Numerator and denominator choice for the shared divider.
  typedef enum logic [1:0] {
    DIV_EUCLID,
    DIV_C,
    DIV_B,
    DIV_A
  } div_sel_t;

  // Operand choice for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_SX,
    MUL_SY
  } mul_sel_t;

  // Register update performed by the datapath in a given cycle.
  typedef enum logic [3:0] {
    WR_NONE,
    WR_QR,
    WR_X,
    WR_Y,
    WR_E,
    WR_SX,
    WR_SY,
    WR_SOLX,
    WR_SOLY
  } wr_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    wr_sel_t  wr;
    logic     out_load;
  } ldsolve_cmd_t;

  typedef struct packed {
    logic rb_zero;
    logic ra_zero;
    logic div_done;
  } ldsolve_stat_t;

endpackage

`default_nettype wire

### design/linear_diophantine_solver.sv
`default_nettype none
// Channel  | Direction | Handshake                    | Contents
// s_axis   | in        | s_axis_tvalid / s_axis_tready | coef_a, coef_b, target_c in tdata
// m_axis   | out       | m_axis_tvalid / m_axis_tready | gcd, Bezout pair, solution, steps;
//          |           |                              | solvable flag in tuser
//
// One item is worked on at a time. Each Euclid step is a check, the iterations of the shared
// bit-serial divider plus its done cycle, two multiplies and an update. After the last
// check the finish is three divides, two multiplies, a store and the output load; when
// the gcd is zero it goes straight to the output load.
// Reset is synchronous and clears the controller and the divider's control bits.
// A waiting result does not block the next item, which stalls only in its final state.

module linear_diophantine_solver
  import ldsolve_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,

  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // From bit 0: coef_a, coef_b, target_c (WIDTH-1 bits each), zero padding.
  input  wire logic [((3*(WIDTH-1)+7)/8)*8-1:0]      s_axis_tdata,

  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // From bit 0: gcd_value, bezout_x, bezout_y, solution_x, solution_y, step_x, step_y,
  // zero padding.
  output logic      [((9*WIDTH-5)+7)/8*8-1:0]        m_axis_tdata,
  // Bit 0: solvable.
  output logic      [0:0]                            m_axis_tuser
);

  localparam int CB     = WIDTH - 1;
  localparam int OUT_W  = ((9*WIDTH-5)+7)/8*8;

  ldsolve_cmd_t  cmd;
  ldsolve_stat_t stat;

  logic        [CB-1:0]      coef_a, coef_b, target_c;
  logic        [CB-1:0]      gcd_value, step_x, step_y;
  logic signed [WIDTH-1:0]   bezout_x, bezout_y;
  logic signed [2*WIDTH-2:0] solution_x, solution_y;
  logic                      solvable;

  assign coef_a   = s_axis_tdata[CB-1:0];
  assign coef_b   = s_axis_tdata[2*CB-1:CB];
  assign target_c = s_axis_tdata[3*CB-1:2*CB];

  // The controller sequences Euclid steps and the finishing divides and multiplies.
  ldsolve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the remainders, coefficient sequences, shared divider and multiplier.
  ldsolve_dp #(.WIDTH(WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .target_c   (target_c),
    .gcd_value  (gcd_value),
    .bezout_x   (bezout_x),
    .bezout_y   (bezout_y),
    .solution_x (solution_x),
    .solution_y (solution_y),
    .step_x     (step_x),
    .step_y     (step_y),
    .solvable   (solvable)
  );

  // The concatenation is unsigned, so the cast pads the top with zeros.
  assign m_axis_tdata = OUT_W'({step_y, step_x, solution_y, solution_x,
                                bezout_y, bezout_x, gcd_value});
  assign m_axis_tuser = solvable;

endmodule

`default_nettype wire

### design/ldsolve_div.sv
`default_nettype none

module ldsolve_div #(
  parameter int N = 31
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [N-1:0] divisor,
  output logic      [N-1:0] quotient,
  output logic      [N-1:0] remainder,
  output logic              done
);

  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  quo;
  logic [N-1:0]  rem;
  logic [N-1:0]  den;
  logic [N:0]    trial;
  logic [N:0]    diff;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign trial = {rem, quo[N-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!diff[N]) begin
        rem <= diff[N-1:0];
        quo <= {quo[N-2:0], 1'b1};
      end else begin
        rem <= trial[N-1:0];
        quo <= {quo[N-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

### design/ldsolve_dp.sv
`default_nettype none

module ldsolve_dp
  import ldsolve_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ldsolve_cmd_t              cmd,
  output ldsolve_stat_t                  stat,
  input  wire logic        [WIDTH-2:0]   coef_a,
  input  wire logic        [WIDTH-2:0]   coef_b,
  input  wire logic        [WIDTH-2:0]   target_c,
  output logic             [WIDTH-2:0]   gcd_value,
  output logic signed      [WIDTH-1:0]   bezout_x,
  output logic signed      [WIDTH-1:0]   bezout_y,
  output logic signed      [2*WIDTH-2:0] solution_x,
  output logic signed      [2*WIDTH-2:0] solution_y,
  output logic             [WIDTH-2:0]   step_x,
  output logic             [WIDTH-2:0]   step_y,
  output logic                           solvable
);

  localparam int CB = WIDTH - 1;

  // Working registers.
  logic        [CB-1:0]      a_reg, b_reg, c_reg;
  logic        [CB-1:0]      ra, rb;
  logic signed [WIDTH-1:0]   xp, xc, yp, yc;
  logic        [CB-1:0]      q_reg, r_reg;
  logic        [CB-1:0]      e_reg, sx_reg, sy_reg;
  logic                      ok_reg;
  logic        [2*WIDTH-2:0] prod;
  logic        [2*WIDTH-2:0] solx_reg, soly_reg;

  // Shared divider.
  logic [CB-1:0] div_num, div_den, div_quo, div_rem;
  logic          div_done;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_EUCLID: begin
        div_num = ra;
        div_den = rb;
      end
      DIV_C: begin
        div_num = c_reg;
        div_den = ra;
      end
      DIV_B: begin
        div_num = b_reg;
        div_den = ra;
      end
      DIV_A: begin
        div_num = a_reg;
        div_den = ra;
      end
    endcase
  end

  ldsolve_div #(.N(CB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Shared multiplier: signed coefficient times unsigned quotient.
  logic signed [WIDTH-1:0]   mul_a;
  logic        [CB-1:0]      mul_b;
  logic signed [2*WIDTH-1:0] prod_full;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X: begin
        mul_a = xc;
        mul_b = q_reg;
      end
      MUL_Y: begin
        mul_a = yc;
        mul_b = q_reg;
      end
      MUL_SX: begin
        mul_a = xp;
        mul_b = e_reg;
      end
      MUL_SY: begin
        mul_a = yp;
        mul_b = e_reg;
      end
    endcase
    prod_full = mul_a * $signed({1'b0, mul_b});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_full[2*WIDTH-2:0];
    end
  end

  // The coefficient sequences stay within the width, so updates modulo 2^WIDTH are exact.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_reg    <= coef_a;
      b_reg    <= coef_b;
      c_reg    <= target_c;
      ra       <= coef_a;
      rb       <= coef_b;
      xp       <= WIDTH'(1);
      xc       <= '0;
      yp       <= '0;
      yc       <= WIDTH'(1);
      e_reg    <= '0;
      sx_reg   <= '0;
      sy_reg   <= '0;
      ok_reg   <= 1'b0;
      solx_reg <= '0;
      soly_reg <= '0;
    end else begin
      case (cmd.wr)
        WR_NONE: ;
        WR_QR: begin
          q_reg <= div_quo;
          r_reg <= div_rem;
        end
        WR_X: begin
          xp <= xc;
          xc <= xp - prod[WIDTH-1:0];
        end
        WR_Y: begin
          yp <= yc;
          yc <= yp - prod[WIDTH-1:0];
          ra <= rb;
          rb <= r_reg;
        end
        WR_E: begin
          e_reg  <= div_quo;
          ok_reg <= (div_rem == '0);
        end
        WR_SX:   sx_reg   <= div_quo;
        WR_SY:   sy_reg   <= div_quo;
        WR_SOLX: solx_reg <= prod;
        WR_SOLY: soly_reg <= prod;
        default: ;
      endcase
    end
  end

  // Output register, separate from the working set.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gcd_value  <= ra;
      bezout_x   <= xp;
      bezout_y   <= yp;
      solution_x <= solx_reg;
      solution_y <= soly_reg;
      step_x     <= sx_reg;
      step_y     <= sy_reg;
      solvable   <= ok_reg;
    end
  end

  assign stat.rb_zero  = (rb == '0);
  assign stat.ra_zero  = (ra == '0);
  assign stat.div_done = div_done;

endmodule

`default_nettype wire

### design/ldsolve_ctrl.sv
`default_nettype none
`include "linear_diophantine_solver_defines.svh"

module ldsolve_ctrl
  import ldsolve_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ldsolve_cmd_t       cmd,
  input  wire ldsolve_stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIVW  = 4'd2;
  localparam logic [3:0] S_MULX  = 4'd3;
  localparam logic [3:0] S_MULY  = 4'd4;
  localparam logic [3:0] S_UPDY  = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_DIVC  = 4'd7;
  localparam logic [3:0] S_DIVB  = 4'd8;
  localparam logic [3:0] S_DIVA  = 4'd9;
  localparam logic [3:0] S_MULSX = 4'd10;
  localparam logic [3:0] S_MULSY = 4'd11;
  localparam logic [3:0] S_SOLY  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state, state_next;
  logic       slot_free;
  logic       accepted;
  logic       div_wait;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign accepted  = in_valid && in_ready;
  assign div_wait  = (state == S_DIVW) || (state == S_DIVC) ||
                     (state == S_DIVB) || (state == S_DIVA);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = DIV_EUCLID;
    cmd.mul_sel   = MUL_X;
    cmd.wr        = WR_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.rb_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.wr     = WR_QR;
          state_next = S_MULX;
        end
      end
      S_MULX: begin
        cmd.mul_en = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        cmd.wr      = WR_X;
        state_next  = S_UPDY;
      end
      S_UPDY: begin
        cmd.wr     = WR_Y;
        state_next = S_CHECK;
      end
      S_FIN: begin
        if (stat.ra_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_C;
          state_next    = S_DIVC;
        end
      end
      S_DIVC: begin
        if (stat.div_done) begin
          cmd.wr        = WR_E;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_B;
          state_next    = S_DIVB;
        end
      end
      S_DIVB: begin
        if (stat.div_done) begin
          cmd.wr        = WR_SX;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_A;
          state_next    = S_DIVA;
        end
      end
      S_DIVA: begin
        if (stat.div_done) begin
          cmd.wr     = WR_SY;
          state_next = S_MULSX;
        end
      end
      S_MULSX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SX;
        state_next  = S_MULSY;
      end
      S_MULSY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SY;
        cmd.wr      = WR_SOLX;
        state_next  = S_SOLY;
      end
      S_SOLY: begin
        cmd.wr     = WR_SOLY;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LDS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accepted, !in_ready, "still idle")
  `LDS_ASSERT_SAME(a_load_into_free_slot, clk, rst, cmd.out_load, slot_free, "lost result")
  `LDS_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.out_load, out_valid, "result not shown")
  `LDS_ASSERT_SAME(a_done_while_waiting, clk, rst, stat.div_done, div_wait, "stray done")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // The block is built at its default width: 31-bit coefficients, 32-bit Bezout
  // coefficients and 63-bit particular solutions.
  localparam int WIDTH = 32;
  localparam int IN_W  = ((3 * (WIDTH - 1) + 7) / 8) * 8;
  localparam int OUT_W = ((9 * WIDTH - 5) + 7) / 8 * 8;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  // The two largest Fibonacci numbers that fit in 31 bits. They force the
  // longest possible chain of Euclid steps.
  localparam logic [30:0] FIB46 = 31'd1836311903;
  localparam logic [30:0] FIB45 = 31'd1134903170;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 350;
  // The drain waits longer than a worst-case item takes.
  localparam int DRAIN_CYCLES = 2000;
  // The limit leaves a wide margin over the slowest legal run, which has 370 items.
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic [30:0] gcd_value;
    logic [31:0] bezout_x;
    logic [31:0] bezout_y;
    logic [62:0] solution_x;
    logic [62:0] solution_y;
    logic [30:0] step_x;
    logic [30:0] step_y;
    logic        solvable;
  } solution_t;

  // A row of the directed part. When known is set, the expected solution is
  // written into the row. Otherwise the predictor supplies it.
  typedef struct {
    logic [30:0] coef_a;
    logic [30:0] coef_b;
    logic [30:0] target_c;
    logic [2:0]  pad;
    bit          known;
    solution_t   result;
  } directed_row_t;

  localparam solution_t NO_RESULT = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // From bit 0: coef_a, coef_b, target_c (31 bits each), 3 padding bits.
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // From bit 0: gcd_value, bezout_x, bezout_y, solution_x, solution_y, step_x,
  // step_y, 5 padding bits.
  logic [OUT_W-1:0] m_axis_tdata;
  // Bit 0: solvable.
  logic [0:0]       m_axis_tuser;

  solution_t       pending_solutions [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  // The first burst starts without a gap, so the first row follows reset directly.
  int              burst_left = 1;
  int              sink_mode = 0;
  int              sink_mode_left = 0;
  int              sink_stall_left = 0;
  directed_row_t   directed_rows [NUM_DIRECTED];

  linear_diophantine_solver #(
    .WIDTH(WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Extended Euclid with quotient steps, carried out in 64-bit integers so that
  // no intermediate product can overflow. The remainders never go above 31 bits.
  function automatic solution_t solve_diophantine(input logic [30:0] a, b, c);
    longint    rem_prev, rem_cur, quot, rem_next;
    longint    x_prev, x_cur, y_prev, y_cur, x_next, y_next;
    longint    divisor, multiple, sol_x, sol_y;
    solution_t res;
    rem_prev = longint'(a);
    rem_cur  = longint'(b);
    x_prev = 1;
    x_cur  = 0;
    y_prev = 0;
    y_cur  = 1;
    while (rem_cur != 0) begin
      quot     = rem_prev / rem_cur;
      rem_next = rem_prev - quot * rem_cur;
      x_next   = x_prev - quot * x_cur;
      y_next   = y_prev - quot * y_cur;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      x_prev   = x_cur;
      x_cur    = x_next;
      y_prev   = y_cur;
      y_cur    = y_next;
    end
    divisor = rem_prev;
    res = '0;
    res.gcd_value = divisor[30:0];
    res.bezout_x  = x_prev[31:0];
    res.bezout_y  = y_prev[31:0];
    // With both coefficients zero there is no gcd to divide by. The solution
    // and step fields then stay zero, and the item is not solvable.
    if (divisor != 0) begin
      multiple = longint'(c) / divisor;
      sol_x = x_prev * multiple;
      sol_y = y_prev * multiple;
      res.solution_x = sol_x[62:0];
      res.solution_y = sol_y[62:0];
      res.step_x     = 31'(longint'(b) / divisor);
      res.step_y     = 31'(longint'(a) / divisor);
      res.solvable   = ((longint'(c) % divisor) == 0);
    end
    return res;
  endfunction

  // Random problems in several flavors. Plain random coefficients are mostly
  // coprime, so shared factors, Fibonacci pairs and degenerate shapes are mixed in
  // to reach long step chains, large gcds and both outcomes of the solvable flag.
  function automatic void pick_problem(output logic [30:0] a, b, c,
                                       output logic [2:0] pad);
    int     kind;
    longint factor, lim, fib_lo, fib_hi, fib_tmp;
    int     idx;
    kind = $urandom_range(0, 99);
    a = 31'($urandom);
    b = 31'($urandom);
    c = 31'($urandom);
    if (kind < 15) begin
      // Shared factor, with c a multiple of it half of the time.
      factor = longint'($urandom_range(1, 1 << $urandom_range(1, 20)));
      lim = longint'(MAX31) / factor;
      a = 31'(factor * longint'($urandom_range(0, 32'(lim))));
      b = 31'(factor * longint'($urandom_range(0, 32'(lim))));
      if ($urandom_range(0, 1) == 1) begin
        c = 31'(factor * longint'($urandom_range(0, 32'(lim))));
      end
    end else if (kind < 25) begin
      a = 31'($urandom_range(0, 50));
      b = 31'($urandom_range(0, 50));
      c = 31'($urandom_range(0, 100));
    end else if (kind < 35) begin
      // Consecutive Fibonacci numbers give the most steps for their size.
      idx = $urandom_range(2, 46);
      fib_lo = 0;
      fib_hi = 1;
      repeat (idx - 1) begin
        fib_tmp = fib_hi + fib_lo;
        fib_lo  = fib_hi;
        fib_hi  = fib_tmp;
      end
      a = 31'(fib_hi);
      b = 31'(fib_lo);
      if ($urandom_range(0, 1) == 1) begin
        a = 31'(fib_lo);
        b = 31'(fib_hi);
      end
    end else if (kind < 45) begin
      // One or both coefficients zero.
      case ($urandom_range(0, 2))
        0: b = '0;
        1: a = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end else if (kind < 55) begin
      // One coefficient an exact multiple of the other, or both equal.
      b = 31'($urandom_range(1, 65535));
      a = 31'(longint'(b) * longint'($urandom_range(0, 32'(longint'(MAX31) / longint'(b)))));
      if ($urandom_range(0, 3) == 0) begin
        a = b;
      end
    end else if (kind < 65) begin
      a = MAX31 - 31'($urandom_range(0, 1000));
      b = MAX31 - 31'($urandom_range(0, 1000));
    end
    case ($urandom_range(0, 9))
      0: c = '0;
      1: c = MAX31;
      default: ;
    endcase
    // The padding bits above target_c must be ignored by the block.
    pad = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b000;
  endfunction

  // The sender works in bursts of one to eight transactions. Between bursts
  // tvalid drops for a random number of cycles, and a third of the bursts
  // follow the previous one with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // One input transaction. The data changes at a falling edge and is held until
  // a rising edge sees tready high. The expected solution is queued at that edge.
  task automatic send_problem(input logic [30:0] a, b, c, input logic [2:0] pad,
                              input solution_t result);
    @(negedge clk);
    s_axis_tdata  <= {pad, c, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_solutions.push_back(result);
  endtask

  initial begin
    logic [30:0] a, b, c;
    logic [2:0]  pad;
    // The rows with a typed result are the degenerate ones, where Euclid takes
    // at most one step. The other rows rely on the predictor. The first row
    // follows reset directly.
    directed_rows = '{
      '{31'd0, 31'd0, 31'd0, 3'b000, 1'b1,
        '{31'd0, 32'd1, 32'd0, 63'd0, 63'd0, 31'd0, 31'd0, 1'b0}},
      '{31'd0, 31'd0, MAX31, 3'b000, 1'b1,
        '{31'd0, 32'd1, 32'd0, 63'd0, 63'd0, 31'd0, 31'd0, 1'b0}},
      '{MAX31, 31'd0, MAX31, 3'b000, 1'b1,
        '{MAX31, 32'd1, 32'd0, 63'd1, 63'd0, 31'd0, 31'd1, 1'b1}},
      '{31'd5, 31'd0, 31'd7, 3'b000, 1'b1,
        '{31'd5, 32'd1, 32'd0, 63'd1, 63'd0, 31'd0, 31'd1, 1'b0}},
      '{MAX31, MAX31, MAX31, 3'b000, 1'b1,
        '{MAX31, 32'd0, 32'd1, 63'd0, 63'd1, 31'd1, 31'd1, 1'b1}},
      '{31'd1, 31'd1, 31'd0, 3'b000, 1'b1,
        '{31'd1, 32'd0, 32'd1, 63'd0, 63'd0, 31'd1, 31'd1, 1'b1}},
      '{31'd0, 31'd7, 31'd21, 3'b000, 1'b1,
        '{31'd7, 32'd0, 32'd1, 63'd0, 63'd3, 31'd1, 31'd0, 1'b1}},
      '{31'd1, 31'd0, MAX31, 3'b000, 1'b1,
        '{31'd1, 32'd1, 32'd0, 63'(MAX31), 63'd0, 31'd0, 31'd1, 1'b1}},
      '{MAX31, 31'd1, 31'd1, 3'b000, 1'b1,
        '{31'd1, 32'd0, 32'd1, 63'd0, 63'd1, 31'd1, MAX31, 1'b1}},
      '{31'd6, 31'd4, 31'd5, 3'b000, 1'b0, NO_RESULT},
      '{31'd12, 31'd18, 31'd7, 3'b000, 1'b0, NO_RESULT},
      '{31'd240, 31'd46, 31'd2, 3'b000, 1'b0, NO_RESULT},
      '{FIB46, FIB45, MAX31, 3'b000, 1'b0, NO_RESULT},
      '{FIB45, FIB46, 31'd0, 3'b000, 1'b0, NO_RESULT},
      '{MAX31, MAX31 - 31'd1, MAX31, 3'b000, 1'b0, NO_RESULT},
      '{31'd2, 31'd0, 31'd3, 3'b111, 1'b0, NO_RESULT},
      '{31'd1073741824, 31'd536870912, 31'd1610612736, 3'b101, 1'b0, NO_RESULT},
      '{MAX31, 31'd2, MAX31, 3'b000, 1'b0, NO_RESULT},
      '{31'd1000000007, 31'd998244353, 31'd123456789, 3'b010, 1'b0, NO_RESULT},
      '{31'd3, 31'd7, 31'd1, 3'b000, 1'b0, NO_RESULT}
    };

    // Reset is held high at the start and released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace_sender();
      send_problem(directed_rows[i].coef_a, directed_rows[i].coef_b,
                   directed_rows[i].target_c, directed_rows[i].pad,
                   directed_rows[i].known ? directed_rows[i].result :
                   solve_diophantine(directed_rows[i].coef_a, directed_rows[i].coef_b,
                                     directed_rows[i].target_c));
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick_problem(a, b, c, pad);
      pace_sender();
      send_problem(a, b, c, pad, solve_diophantine(a, b, c));
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Let every queued solution come out, then watch a while longer for any
    // transaction that nobody asked for.
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_solutions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The receiver switches among three habits after spans of random length:
  // always ready, ready at random three times in four, and long stalls
  // broken by single ready cycles. The switch points are unrelated to the
  // block's timing, so stalls land on every part of its work.
  always @(negedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      = $urandom_range(0, 2);
      sink_mode_left = $urandom_range(64, 512);
    end
    sink_mode_left--;
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (sink_stall_left == 0) begin
          sink_stall_left = $urandom_range(0, 40);
          m_axis_tready <= 1'b1;
        end else begin
          sink_stall_left--;
          m_axis_tready <= 1'b0;
        end
      end
    endcase
  end

  // Every output transaction is unpacked and compared field by field with the
  // oldest queued solution.
  always @(posedge clk) begin
    solution_t got;
    solution_t want;
    string     bad_fields;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.gcd_value  = m_axis_tdata[30:0];
      got.bezout_x   = m_axis_tdata[62:31];
      got.bezout_y   = m_axis_tdata[94:63];
      got.solution_x = m_axis_tdata[157:95];
      got.solution_y = m_axis_tdata[220:158];
      got.step_x     = m_axis_tdata[251:221];
      got.step_y     = m_axis_tdata[282:252];
      got.solvable   = m_axis_tuser[0];
      if (pending_solutions.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: output transaction with no solution pending, gcd %0h",
                   $realtime, got.gcd_value);
        end
        mismatch_count++;
      end else begin
        want = pending_solutions.pop_front();
        bad_fields = "";
        if (got.gcd_value !== want.gcd_value) bad_fields = {bad_fields, " gcd_value"};
        if (got.bezout_x !== want.bezout_x) bad_fields = {bad_fields, " bezout_x"};
        if (got.bezout_y !== want.bezout_y) bad_fields = {bad_fields, " bezout_y"};
        if (got.solution_x !== want.solution_x) bad_fields = {bad_fields, " solution_x"};
        if (got.solution_y !== want.solution_y) bad_fields = {bad_fields, " solution_y"};
        if (got.step_x !== want.step_x) bad_fields = {bad_fields, " step_x"};
        if (got.step_y !== want.step_y) bad_fields = {bad_fields, " step_y"};
        if (got.solvable !== want.solvable) bad_fields = {bad_fields, " solvable"};
        if (bad_fields != "") begin
          if (mismatch_count < 10) begin
            $display("%0t: wrong field(s):%s", $realtime, bad_fields);
            $display("  expected gcd %h bx %h by %h sx %h sy %h stx %h sty %h ok %b",
                     want.gcd_value, want.bezout_x, want.bezout_y, want.solution_x,
                     want.solution_y, want.step_x, want.step_y, want.solvable);
            $display("  actual   gcd %h bx %h by %h sx %h sy %h stx %h sty %h ok %b",
                     got.gcd_value, got.bezout_x, got.bezout_y, got.solution_x,
                     got.solution_y, got.step_x, got.step_y, got.solvable);
          end
          mismatch_count++;
        end
      end
    end
  end

  // A hung block or handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
